// File: rtl/grc_pkg.sv
// ----------------------------------------------------------------------------
// grc_pkg
// Shared constants, codes and controller/datapath interface types for the
// gradient color ramp.
// ----------------------------------------------------------------------------
package grc_pkg;

    // table size and field widths
    localparam int MAX_STOPS = 16;
    localparam int POS_W     = 17;
    localparam int COLOR_W   = 32;
    localparam int CHAN_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int LANES     = 4;
    localparam int ADDR_W    = $clog2(MAX_STOPS);
    localparam int CNT_W     = $clog2(MAX_STOPS + 1);

    // divider widths: numerator < 512 * span, divisor = 2 * span
    localparam int REM_W = POS_W + CHAN_W + 2;
    localparam int DIV_W = POS_W + 1;
    localparam int DSH_W = DIV_W + CHAN_W - 1;
    localparam int BIT_W = $clog2(CHAN_W);

    localparam logic [POS_W-1:0] ONE_Q16 = POS_W'(65536);

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_COLOR   = 2'd0,
        ST_STORED  = 2'd1,
        ST_DROPPED = 2'd2
    } t_status;

    // table read address source
    typedef enum logic [1:0] {
        RA_IDX,
        RA_IDX_M1,
        RA_ZERO,
        RA_LAST
    } t_rd_addr;

    // index register update
    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_COUNT,
        IDX_ONE,
        IDX_DEC,
        IDX_INC
    } t_idx_op;

    // output register source
    typedef enum logic [2:0] {
        OS_STORED,
        OS_DROPPED,
        OS_EMPTY,
        OS_LO,
        OS_HI,
        OS_BLEND
    } t_out_sel;

    // controller -> datapath
    typedef struct packed {
        logic     load_in;
        logic     rd_en;
        t_rd_addr rd_sel;
        logic     wr_en;
        logic     wr_new;
        t_idx_op  idx_op;
        logic     cnt_inc;
        logic     save_lo;
        logic     save_hi;
        logic     div_start;
        logic     div_step;
        logic     out_load;
        t_out_sel out_sel;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic mode;
        logic full;
        logic empty;
        logic slot_zero;
        logic rd_gt_pos;
        logic pos_le_first;
        logic pos_ge_last;
        logic scan_end;
        logic span_zero;
        logic div_last;
    } t_sts;

    // channel of a packed ARGB word; lane 0 red, 1 green, 2 blue, 3 alpha
    function automatic logic [CHAN_W-1:0] chan_of(input logic [COLOR_W-1:0] word,
                                                  input logic [1:0] lane);
        logic [CHAN_W-1:0] c;
        case (lane)
            2'd0:    c = word[23:16];
            2'd1:    c = word[15:8];
            2'd2:    c = word[7:0];
            default: c = word[31:24];
        endcase
        return c;
    endfunction

endpackage

// File: rtl/grc_ctrl.sv
// ----------------------------------------------------------------------------
// grc_ctrl
// Sequencer for the ramp: sorted insert, clamp checks, pair search, divider
// run and output register handshake.
// ----------------------------------------------------------------------------
module grc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output grc_pkg::t_cmd o_cmd,
    input  grc_pkg::t_sts i_sts
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_ADD_CHK,
        S_ADD_CMP,
        S_FIRST,
        S_LAST,
        S_RD,
        S_SCAN,
        S_DIV_INIT,
        S_DIV,
        S_FIN
    } t_state;

    t_state            r_state, n_state;
    grc_pkg::t_out_sel r_out_sel, n_out_sel;
    logic              r_out_valid, n_out_valid;
    grc_pkg::t_cmd     w_cmd;

    // next state and commands
    always_comb begin
        n_state            = r_state;
        n_out_sel          = r_out_sel;
        w_cmd              = '0;
        w_cmd.rd_sel       = grc_pkg::RA_IDX;
        w_cmd.idx_op       = grc_pkg::IDX_HOLD;
        w_cmd.out_sel      = r_out_sel;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load_in = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (!i_sts.mode) begin
                    if (i_sts.full) begin
                        n_out_sel = grc_pkg::OS_DROPPED;
                        n_state   = S_FIN;
                    end else begin
                        w_cmd.idx_op = grc_pkg::IDX_COUNT;
                        n_state      = S_ADD_CHK;
                    end
                end else if (i_sts.empty) begin
                    n_out_sel = grc_pkg::OS_EMPTY;
                    n_state   = S_FIN;
                end else begin
                    w_cmd.rd_en  = 1'b1;
                    w_cmd.rd_sel = grc_pkg::RA_ZERO;
                    n_state      = S_FIRST;
                end
            end
            // insertion: walk down from the end, shifting larger offsets up
            S_ADD_CHK: begin
                if (i_sts.slot_zero) begin
                    w_cmd.wr_en   = 1'b1;
                    w_cmd.wr_new  = 1'b1;
                    w_cmd.cnt_inc = 1'b1;
                    n_out_sel     = grc_pkg::OS_STORED;
                    n_state       = S_FIN;
                end else begin
                    w_cmd.rd_en  = 1'b1;
                    w_cmd.rd_sel = grc_pkg::RA_IDX_M1;
                    n_state      = S_ADD_CMP;
                end
            end
            S_ADD_CMP: begin
                w_cmd.wr_en = 1'b1;
                if (i_sts.rd_gt_pos) begin
                    w_cmd.idx_op = grc_pkg::IDX_DEC;
                    n_state      = S_ADD_CHK;
                end else begin
                    w_cmd.wr_new  = 1'b1;
                    w_cmd.cnt_inc = 1'b1;
                    n_out_sel     = grc_pkg::OS_STORED;
                    n_state       = S_FIN;
                end
            end
            // clamp below the first stop
            S_FIRST: begin
                w_cmd.save_lo = 1'b1;
                if (i_sts.pos_le_first) begin
                    n_out_sel = grc_pkg::OS_LO;
                    n_state   = S_FIN;
                end else begin
                    w_cmd.rd_en  = 1'b1;
                    w_cmd.rd_sel = grc_pkg::RA_LAST;
                    n_state      = S_LAST;
                end
            end
            // clamp above the last stop
            S_LAST: begin
                w_cmd.save_hi = 1'b1;
                if (i_sts.pos_ge_last) begin
                    n_out_sel = grc_pkg::OS_HI;
                    n_state   = S_FIN;
                end else begin
                    w_cmd.idx_op = grc_pkg::IDX_ONE;
                    n_state      = S_RD;
                end
            end
            // pair search: each stop is read in S_RD, then compared in S_SCAN
            S_RD: begin
                w_cmd.rd_en  = 1'b1;
                w_cmd.rd_sel = grc_pkg::RA_IDX;
                n_state      = S_SCAN;
            end
            S_SCAN: begin
                w_cmd.save_hi = 1'b1;
                if (i_sts.scan_end) begin
                    n_state = S_DIV_INIT;
                end else begin
                    w_cmd.save_lo = 1'b1;
                    w_cmd.idx_op  = grc_pkg::IDX_INC;
                    n_state       = S_RD;
                end
            end
            S_DIV_INIT: begin
                if (i_sts.span_zero) begin
                    n_out_sel = grc_pkg::OS_LO;
                    n_state   = S_FIN;
                end else begin
                    w_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                w_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_out_sel = grc_pkg::OS_BLEND;
                    n_state   = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // output register occupancy
        if (w_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_sel   <= grc_pkg::OS_EMPTY;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_sel   <= n_out_sel;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

endmodule

// File: rtl/grc_dp.sv
// ----------------------------------------------------------------------------
// grc_dp
// Datapath: stop table memory, index and count registers, compares, four
// restoring divider lanes and the result register.
// ----------------------------------------------------------------------------
module grc_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  grc_pkg::t_cmd                       i_cmd,
    output grc_pkg::t_sts                       o_sts,
    input  logic                                i_in_mode,
    input  logic [grc_pkg::POS_W-1:0]           i_in_pos,
    input  logic [grc_pkg::COLOR_W-1:0]         i_in_word,
    output logic [grc_pkg::CHAN_W-1:0]          o_red,
    output logic [grc_pkg::CHAN_W-1:0]          o_green,
    output logic [grc_pkg::CHAN_W-1:0]          o_blue,
    output logic [grc_pkg::CHAN_W-1:0]          o_alpha,
    output logic [grc_pkg::STATUS_W-1:0]        o_status
);

    // input word
    logic                          r_mode;
    logic [grc_pkg::POS_W-1:0]     r_pos;
    logic [grc_pkg::COLOR_W-1:0]   r_word;

    // table state
    logic [grc_pkg::POS_W-1:0]     mem_off [grc_pkg::MAX_STOPS];
    logic [grc_pkg::COLOR_W-1:0]   mem_col [grc_pkg::MAX_STOPS];
    logic [grc_pkg::POS_W-1:0]     r_rd_off;
    logic [grc_pkg::COLOR_W-1:0]   r_rd_col;
    logic [grc_pkg::CNT_W-1:0]     r_count;
    logic [grc_pkg::CNT_W-1:0]     r_idx;

    // enclosing pair
    logic [grc_pkg::POS_W-1:0]     r_o0, r_o1;
    logic [grc_pkg::COLOR_W-1:0]   r_c0, r_c1;

    // divider
    logic [grc_pkg::REM_W-1:0]     r_rem [grc_pkg::LANES];
    logic [grc_pkg::CHAN_W-1:0]    r_q   [grc_pkg::LANES];
    logic [grc_pkg::DSH_W-1:0]     r_dsh;
    logic [grc_pkg::BIT_W-1:0]     r_bit;

    // result
    logic [grc_pkg::CHAN_W-1:0]    r_red, r_green, r_blue, r_alpha;
    logic [grc_pkg::STATUS_W-1:0]  r_status;

    logic [grc_pkg::CNT_W-1:0]     w_idx_m1, w_cnt_m1, w_idx_p1;
    logic [grc_pkg::ADDR_W-1:0]    w_raddr;
    logic [grc_pkg::POS_W-1:0]     w_d, w_span, w_nd;
    logic [grc_pkg::REM_W-1:0]     w_num [grc_pkg::LANES];
    logic [grc_pkg::REM_W-1:0]     w_dsh_ext;

    assign w_idx_m1  = r_idx - grc_pkg::CNT_W'(1);
    assign w_idx_p1  = r_idx + grc_pkg::CNT_W'(1);
    assign w_cnt_m1  = r_count - grc_pkg::CNT_W'(1);
    assign w_d       = r_pos - r_o0;
    assign w_span    = r_o1 - r_o0;
    assign w_nd      = w_span - w_d;
    assign w_dsh_ext = grc_pkg::REM_W'(r_dsh);

    // read address select
    always_comb begin
        case (i_cmd.rd_sel)
            grc_pkg::RA_IDX:    w_raddr = r_idx[grc_pkg::ADDR_W-1:0];
            grc_pkg::RA_IDX_M1: w_raddr = w_idx_m1[grc_pkg::ADDR_W-1:0];
            grc_pkg::RA_ZERO:   w_raddr = '0;
            default:            w_raddr = w_cnt_m1[grc_pkg::ADDR_W-1:0];
        endcase
    end

    // numerator per lane: 2*(c0*(n-d) + c1*d) + n
    for (genvar g = 0; g < grc_pkg::LANES; g++) begin : g_num
        localparam logic [1:0] LANE = 2'(g);
        assign w_num[g] = ((grc_pkg::REM_W'(grc_pkg::chan_of(r_c0, LANE))
                            * grc_pkg::REM_W'(w_nd)
                          + grc_pkg::REM_W'(grc_pkg::chan_of(r_c1, LANE))
                            * grc_pkg::REM_W'(w_d)) << 1)
                        + grc_pkg::REM_W'(w_span);
    end

    // status to controller
    always_comb begin
        o_sts.mode         = r_mode;
        o_sts.full         = (r_count == grc_pkg::CNT_W'(grc_pkg::MAX_STOPS));
        o_sts.empty        = (r_count == '0);
        o_sts.slot_zero    = (r_idx == '0);
        o_sts.rd_gt_pos    = (r_rd_off > r_pos);
        o_sts.pos_le_first = (r_pos <= r_rd_off);
        o_sts.pos_ge_last  = (r_pos >= grc_pkg::ONE_Q16) || (r_pos >= r_rd_off);
        o_sts.scan_end     = (w_idx_p1 == r_count) || (r_pos < r_rd_off);
        o_sts.span_zero    = (r_o1 == r_o0);
        o_sts.div_last     = (r_bit == '0);
    end

    // stop count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + grc_pkg::CNT_W'(1);
        end
    end

    // stop table: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            if (i_cmd.wr_new) begin
                mem_off[r_idx[grc_pkg::ADDR_W-1:0]] <= r_pos;
                mem_col[r_idx[grc_pkg::ADDR_W-1:0]] <= r_word;
            end else begin
                mem_off[r_idx[grc_pkg::ADDR_W-1:0]] <= r_rd_off;
                mem_col[r_idx[grc_pkg::ADDR_W-1:0]] <= r_rd_col;
            end
        end
        if (i_cmd.rd_en) begin
            r_rd_off <= mem_off[w_raddr];
            r_rd_col <= mem_col[w_raddr];
        end
    end

    // input capture, index and pair registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mode <= i_in_mode;
            r_pos  <= i_in_pos;
            r_word <= i_in_word;
        end
        case (i_cmd.idx_op)
            grc_pkg::IDX_COUNT: r_idx <= r_count;
            grc_pkg::IDX_ONE:   r_idx <= grc_pkg::CNT_W'(1);
            grc_pkg::IDX_DEC:   r_idx <= w_idx_m1;
            grc_pkg::IDX_INC:   r_idx <= w_idx_p1;
            default:            r_idx <= r_idx;
        endcase
        if (i_cmd.save_lo) begin
            r_o0 <= r_rd_off;
            r_c0 <= r_rd_col;
        end
        if (i_cmd.save_hi) begin
            r_o1 <= r_rd_off;
            r_c1 <= r_rd_col;
        end
    end

    // restoring division, one quotient bit per cycle in every lane
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dsh <= grc_pkg::DSH_W'({w_span, 1'b0}) << (grc_pkg::CHAN_W - 1);
            r_bit <= grc_pkg::BIT_W'(grc_pkg::CHAN_W - 1);
        end else if (i_cmd.div_step) begin
            r_dsh <= r_dsh >> 1;
            r_bit <= r_bit - grc_pkg::BIT_W'(1);
        end
        for (int l = 0; l < grc_pkg::LANES; l++) begin
            if (i_cmd.div_start) begin
                r_rem[l] <= w_num[l];
                r_q[l]   <= '0;
            end else if (i_cmd.div_step) begin
                if (r_rem[l] >= w_dsh_ext) begin
                    r_rem[l] <= r_rem[l] - w_dsh_ext;
                    r_q[l]   <= {r_q[l][grc_pkg::CHAN_W-2:0], 1'b1};
                end else begin
                    r_q[l]   <= {r_q[l][grc_pkg::CHAN_W-2:0], 1'b0};
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            case (i_cmd.out_sel)
                grc_pkg::OS_LO: begin
                    r_red    <= grc_pkg::chan_of(r_c0, 2'd0);
                    r_green  <= grc_pkg::chan_of(r_c0, 2'd1);
                    r_blue   <= grc_pkg::chan_of(r_c0, 2'd2);
                    r_alpha  <= grc_pkg::chan_of(r_c0, 2'd3);
                    r_status <= grc_pkg::ST_COLOR;
                end
                grc_pkg::OS_HI: begin
                    r_red    <= grc_pkg::chan_of(r_c1, 2'd0);
                    r_green  <= grc_pkg::chan_of(r_c1, 2'd1);
                    r_blue   <= grc_pkg::chan_of(r_c1, 2'd2);
                    r_alpha  <= grc_pkg::chan_of(r_c1, 2'd3);
                    r_status <= grc_pkg::ST_COLOR;
                end
                grc_pkg::OS_BLEND: begin
                    r_red    <= r_q[0];
                    r_green  <= r_q[1];
                    r_blue   <= r_q[2];
                    r_alpha  <= r_q[3];
                    r_status <= grc_pkg::ST_COLOR;
                end
                grc_pkg::OS_STORED: begin
                    r_red    <= '0;
                    r_green  <= '0;
                    r_blue   <= '0;
                    r_alpha  <= '0;
                    r_status <= grc_pkg::ST_STORED;
                end
                grc_pkg::OS_DROPPED: begin
                    r_red    <= '0;
                    r_green  <= '0;
                    r_blue   <= '0;
                    r_alpha  <= '0;
                    r_status <= grc_pkg::ST_DROPPED;
                end
                default: begin
                    r_red    <= '0;
                    r_green  <= '0;
                    r_blue   <= '0;
                    r_alpha  <= '0;
                    r_status <= grc_pkg::ST_COLOR;
                end
            endcase
        end
    end

    assign o_red    = r_red;
    assign o_green  = r_green;
    assign o_blue   = r_blue;
    assign o_alpha  = r_alpha;
    assign o_status = r_status;

endmodule

// File: rtl/gradient_color_ramp.sv
// ----------------------------------------------------------------------------
// gradient_color_ramp
// Color stop table with sorted insert and linear interpolation sampling.
// ----------------------------------------------------------------------------
// Input stream: tuser selects the word kind (0 add a stop, 1 sample), tdata
// carries the Q1.16 position/offset and, for adds, the ARGB stop color.
// Output stream: one word per input word; tdata holds R, G, B, A, tuser the
// status (color valid, stop stored, stop dropped because the table is full).
// One word is in work at a time; tready drops from acceptance until the
// result is placed in the output register.
// Work per word: a dropped add goes straight to the output register; a stored
// add shifts each larger stop up one place, then writes the new stop; a
// sample on an empty table yields zero color; a sample at or below the first
// stop, or at or above the last stop or 1.0, takes that stop's color; any other
// sample searches for the enclosing pair, then runs the quotient loop.
// The stop table read is registered, so each stop visited takes a read state
// and a compare state, and the quotient loop yields one bit per step.
// The output register decouples the sides: a stalled receiver holds the
// result stable, the next input word is still accepted and worked, and its
// result waits until the register frees up.
// Synchronous reset empties the table and drops any pending result; no
// clearing sweep is needed.
// ----------------------------------------------------------------------------
module gradient_color_ramp (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [55:0] i_s_axis_tdata,   // position[16:0], color_word[48:17], pad
    input  logic        i_s_axis_tuser,   // mode[0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    output logic [1:0]  o_m_axis_tuser    // status[1:0]
);

    grc_pkg::t_cmd                  w_cmd;
    grc_pkg::t_sts                  w_sts;
    logic [grc_pkg::CHAN_W-1:0]     w_red, w_green, w_blue, w_alpha;
    logic [grc_pkg::STATUS_W-1:0]   w_status;

    // sequencer
    grc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // datapath
    grc_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .i_in_mode (i_s_axis_tuser),
        .i_in_pos  (i_s_axis_tdata[16:0]),
        .i_in_word (i_s_axis_tdata[48:17]),
        .o_red     (w_red),
        .o_green   (w_green),
        .o_blue    (w_blue),
        .o_alpha   (w_alpha),
        .o_status  (w_status)
    );

    assign o_m_axis_tdata = {w_alpha, w_blue, w_green, w_red};
    assign o_m_axis_tuser = w_status;

endmodule

// File: rtl/grc_checker.sv
// ----------------------------------------------------------------------------
// grc_checker
// Port-level checks on the gradient color ramp, bound to the top level.
// ----------------------------------------------------------------------------
module grc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);

    // stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result word withdrawn while stalled");

    // stalled result does not change
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result word changed while stalled");

    // one word in work: input closes after each acceptance
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input accepted on consecutive cycles");

    // status code range
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tuser <= grc_pkg::ST_DROPPED)
        else $error("undefined status code");

    // add results carry no color
    a_add_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == grc_pkg::ST_STORED ||
                            o_m_axis_tuser == grc_pkg::ST_DROPPED)
            |-> o_m_axis_tdata == 32'd0)
        else $error("nonzero color on an add result");

endmodule

bind gradient_color_ramp grc_checker u_grc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
